// ----- hw/rtl/bbu_pkg.sv -----
// Shared types, constants and helper functions of the bin block upscaler.
package bbu_pkg;

  localparam int unsigned DIM_W     = 13;  // frame and bin dimension registers
  localparam int unsigned COORD_W   = 12;  // raster coordinates
  localparam int unsigned CNT_W     = 7;   // bin counts per axis
  localparam int unsigned VAL_W     = 16;  // bin and pixel values
  localparam int unsigned STORE_AW  = 12;  // bin store address
  localparam int unsigned STORE_DEPTH = 1 << STORE_AW;
  localparam int unsigned MAX_BINS  = 64;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned CFG_IDX_W = 3;

  // Largest usable dimension, 2^COORD_W
  localparam logic [DIM_W-1:0] DIM_LIMIT = DIM_W'(1 << COORD_W);

  // Item kinds
  localparam logic [1:0] KIND_LOAD   = 2'd0;
  localparam logic [1:0] KIND_UPD_XY = 2'd1;
  localparam logic [1:0] KIND_UPD_IX = 2'd2;
  localparam logic [1:0] KIND_TICK   = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_W  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_H  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BIN_W    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BIN_H    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BINS_X   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BINS_Y   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_TWO_BYTE = 3'd6;

  // Divider jobs run after reset and after each configuration write
  localparam logic [1:0] JOB_COLS  = 2'd0;  // frame width / bin width
  localparam logic [1:0] JOB_ROWS  = 2'd1;  // frame height / bin height
  localparam logic [1:0] JOB_SEEDX = 2'd2;  // raster x position within bins
  localparam logic [1:0] JOB_SEEDY = 2'd3;  // raster y position within bins

  // Commands from the controller to the datapath
  typedef struct packed {
    logic                clr_we;
    logic [STORE_AW-1:0] clr_addr;
    logic                div_start;
    logic [1:0]          job;
    logic                margin_ld;
    logic                run;
    logic                cfg_open;
  } bbu_cmd_t;

  // Status from the datapath
  typedef struct packed {
    logic div_done;
    logic can_take;
  } bbu_stat_t;

  // Zero reads as one, oversized reads as the limit
  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    r = v;
    if (v == '0) r = DIM_W'(1);
    else if (v > DIM_LIMIT) r = DIM_LIMIT;
    return r;
  endfunction

endpackage

// ----- hw/rtl/bbu_div.sv -----
// Restoring divider, one quotient bit per cycle.
module bbu_div (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [bbu_pkg::DIM_W-1:0] dividend_i,
  input  logic [bbu_pkg::DIM_W-1:0] divisor_i,
  output logic                     done_o,
  output logic [bbu_pkg::DIM_W-1:0] quot_o,
  output logic [bbu_pkg::DIM_W-1:0] rem_o
);
  import bbu_pkg::*;

  localparam int unsigned STEP_W = $clog2(DIM_W);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [DIM_W-1:0]  quo_q, quo_d;
  logic [DIM_W-1:0]  rem_q, rem_d;
  logic [DIM_W-1:0]  dvs_q, dvs_d;
  logic [DIM_W:0]    trial;
  logic              fits;

  // Operand load on start, else one shift-subtract step while busy
  always_comb begin
    trial  = {rem_q, quo_q[DIM_W-1]};
    fits   = trial >= {1'b0, dvs_q};
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = '0;
      quo_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      quo_d = {quo_q[DIM_W-2:0], fits};
      rem_d = fits ? DIM_W'(trial - {1'b0, dvs_q}) : trial[DIM_W-1:0];
      if (step_q == STEP_W'(DIM_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        step_d = step_q + STEP_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign done_o = done_q;
  assign quot_o = quo_q;
  assign rem_o  = rem_q;

endmodule

// ----- hw/rtl/bbu_datapath.sv -----
// Datapath: config registers, geometry, raster tracker, bin store and output stages.
module bbu_datapath (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  bbu_pkg::bbu_cmd_t              cmd_i,
  output bbu_pkg::bbu_stat_t             stat_o,
  // configuration
  input  logic                           cfg_fire_i,
  input  logic [bbu_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [bbu_pkg::DIM_W-1:0]      cfg_data_i,
  // request
  input  logic                           in_fire_i,
  input  logic [1:0]                     kind_i,
  input  logic [5:0]                     bin_column_i,
  input  logic [5:0]                     bin_row_i,
  input  logic [bbu_pkg::STORE_AW-1:0]   bin_index_i,
  input  logic [bbu_pkg::VAL_W-1:0]      bin_value_i,
  // result
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [bbu_pkg::VAL_W-1:0]      pixel_value_o,
  output logic [bbu_pkg::COORD_W-1:0]    pixel_x_o,
  output logic [bbu_pkg::COORD_W-1:0]    pixel_y_o,
  output logic                           inside_bins_o,
  output logic                           frame_end_o
);
  import bbu_pkg::*;

  // Configuration registers
  logic [DIM_W-1:0] frame_w_q, frame_h_q, bin_w_q, bin_h_q;
  logic [CNT_W-1:0] req_x_q, req_y_q;
  logic             two_byte_q;

  // Geometry
  logic [CNT_W-1:0]   cba_q, cbd_q;
  logic [COORD_W-1:0] left_q, top_q;

  // Raster tracker
  logic [COORD_W-1:0] x_q, x_d, y_q, y_d;
  logic [CNT_W-1:0]   cx_q, cx_d, cy_q, cy_d;
  logic [COORD_W-1:0] ox_q, ox_d, oy_q, oy_d;

  logic [DIM_W-1:0] fw_eff, fh_eff, bw_eff, bh_eff;

  assign fw_eff = eff_dim(frame_w_q);
  assign fh_eff = eff_dim(frame_h_q);
  assign bw_eff = eff_dim(bin_w_q);
  assign bh_eff = eff_dim(bin_h_q);

  // Config writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_w_q  <= DIM_W'(512);
      frame_h_q  <= DIM_W'(512);
      bin_w_q    <= DIM_W'(1);
      bin_h_q    <= DIM_W'(1);
      req_x_q    <= '0;
      req_y_q    <= '0;
      two_byte_q <= 1'b1;
    end else if (cfg_fire_i) begin
      case (cfg_index_i)
        REG_FRAME_W:  frame_w_q  <= cfg_data_i;
        REG_FRAME_H:  frame_h_q  <= cfg_data_i;
        REG_BIN_W:    bin_w_q    <= cfg_data_i;
        REG_BIN_H:    bin_h_q    <= cfg_data_i;
        REG_BINS_X:   req_x_q    <= cfg_data_i[CNT_W-1:0];
        REG_BINS_Y:   req_y_q    <= cfg_data_i[CNT_W-1:0];
        REG_TWO_BYTE: two_byte_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Shared divider with operand select per job
  logic [DIM_W-1:0] dvd, dvs, quot, rem;
  logic             div_done;

  always_comb begin
    case (cmd_i.job)
      JOB_COLS: begin
        dvd = fw_eff;
        dvs = bw_eff;
      end
      JOB_ROWS: begin
        dvd = fh_eff;
        dvs = bh_eff;
      end
      JOB_SEEDX: begin
        dvd = (x_q >= left_q) ? {1'b0, x_q - left_q} : '0;
        dvs = bw_eff;
      end
      default: begin
        dvd = (y_q >= top_q) ? {1'b0, y_q - top_q} : '0;
        dvs = bh_eff;
      end
    endcase
  end

  bbu_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (dvd),
    .divisor_i  (dvs),
    .done_o     (div_done),
    .quot_o     (quot),
    .rem_o      (rem)
  );

  // Bin count clamp: request, bins that fit, and the axis maximum
  logic [CNT_W-1:0] fit_cnt, clamp_cnt, req_sel;
  assign req_sel   = (cmd_i.job == JOB_COLS) ? req_x_q : req_y_q;
  assign fit_cnt   = (quot > DIM_W'(MAX_BINS)) ? CNT_W'(MAX_BINS) : quot[CNT_W-1:0];
  assign clamp_cnt = (req_sel > fit_cnt) ? fit_cnt : req_sel;

  // Centering margins: half of the leftover extent
  logic [CNT_W+DIM_W-1:0] span_x, span_y;
  logic [DIM_W-1:0]       rest_x, rest_y;
  assign span_x = (CNT_W+DIM_W)'(cba_q) * (CNT_W+DIM_W)'(bw_eff);
  assign span_y = (CNT_W+DIM_W)'(cbd_q) * (CNT_W+DIM_W)'(bh_eff);
  assign rest_x = fw_eff - span_x[DIM_W-1:0];
  assign rest_y = fh_eff - span_y[DIM_W-1:0];

  // Seeded bin position, saturated at the used count
  logic [CNT_W-1:0] seed_cnt;
  logic [CNT_W-1:0] seed_lim;
  assign seed_lim = (cmd_i.job == JOB_SEEDX) ? cba_q : cbd_q;
  assign seed_cnt = (quot > {{(DIM_W-CNT_W){1'b0}}, seed_lim}) ? seed_lim : quot[CNT_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cba_q  <= '0;
      cbd_q  <= '0;
      left_q <= '0;
      top_q  <= '0;
    end else begin
      if (div_done && cmd_i.job == JOB_COLS) cba_q <= clamp_cnt;
      if (div_done && cmd_i.job == JOB_ROWS) cbd_q <= clamp_cnt;
      if (cmd_i.margin_ld) begin
        left_q <= rest_x[DIM_W-1:1];
        top_q  <= rest_y[DIM_W-1:1];
      end
    end
  end

  // Request decode
  logic is_tick, upd_ok, item_we;
  assign is_tick = kind_i == KIND_TICK;
  assign upd_ok  = ({1'b0, bin_column_i} < cba_q) && ({1'b0, bin_row_i} < cbd_q);
  always_comb begin
    case (kind_i)
      KIND_LOAD, KIND_UPD_IX: item_we = in_fire_i;
      KIND_UPD_XY:            item_we = in_fire_i && upd_ok;
      default:                item_we = 1'b0;
    endcase
  end

  // Row-major bin address: row * used_across + column
  logic [CNT_W-1:0]   mul_a, add_b;
  logic [2*CNT_W:0]   grid_addr;
  assign mul_a     = is_tick ? cy_q : {1'b0, bin_row_i};
  assign add_b     = is_tick ? cx_q : {1'b0, bin_column_i};
  assign grid_addr = (2*CNT_W+1)'(mul_a * cba_q) + (2*CNT_W+1)'(add_b);

  logic [STORE_AW-1:0] mem_addr;
  logic [VAL_W-1:0]    mem_wdata;
  logic                mem_we, mem_re;

  always_comb begin
    mem_addr  = grid_addr[STORE_AW-1:0];
    mem_wdata = {bin_value_i[BYTE_W-1:0], {BYTE_W{1'b0}}};
    if (kind_i == KIND_LOAD || kind_i == KIND_UPD_IX) mem_addr = bin_index_i;
    if (kind_i == KIND_LOAD) mem_wdata = bin_value_i;
    if (cmd_i.clr_we) begin
      mem_addr  = cmd_i.clr_addr;
      mem_wdata = '0;
    end
  end
  assign mem_we = cmd_i.clr_we || item_we;
  assign mem_re = in_fire_i && is_tick;

  // Bin store
  logic [VAL_W-1:0] bin_store_q [STORE_DEPTH];
  logic [VAL_W-1:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) bin_store_q[mem_addr] <= mem_wdata;
    if (mem_re) rd_q <= bin_store_q[mem_addr];
  end

  // Raster position and pixel classification
  logic [DIM_W-1:0] x_inc, y_inc;
  logic             end_x, end_y, in_area;
  assign x_inc   = {1'b0, x_q} + DIM_W'(1);
  assign y_inc   = {1'b0, y_q} + DIM_W'(1);
  assign end_x   = x_inc >= fw_eff;
  assign end_y   = y_inc >= fh_eff;
  assign in_area = (x_q >= left_q) && (cx_q < cba_q) && (y_q >= top_q) && (cy_q < cbd_q);

  // Tracker update: bin and offset follow the raster incrementally
  always_comb begin
    x_d  = x_q;
    y_d  = y_q;
    cx_d = cx_q;
    cy_d = cy_q;
    ox_d = ox_q;
    oy_d = oy_q;
    if (in_fire_i && is_tick) begin
      if (end_x) begin
        x_d  = '0;
        cx_d = '0;
        ox_d = '0;
        y_d  = end_y ? '0 : y_inc[COORD_W-1:0];
        if (end_y || y_inc <= {1'b0, top_q}) begin
          cy_d = '0;
          oy_d = '0;
        end else if ({1'b0, oy_q} + DIM_W'(1) == bh_eff) begin
          oy_d = '0;
          if (cy_q < cbd_q) cy_d = cy_q + CNT_W'(1);
        end else begin
          oy_d = oy_q + COORD_W'(1);
        end
      end else begin
        x_d = x_inc[COORD_W-1:0];
        if (x_inc <= {1'b0, left_q}) begin
          cx_d = '0;
          ox_d = '0;
        end else if ({1'b0, ox_q} + DIM_W'(1) == bw_eff) begin
          ox_d = '0;
          if (cx_q < cba_q) cx_d = cx_q + CNT_W'(1);
        end else begin
          ox_d = ox_q + COORD_W'(1);
        end
      end
    end else if (cfg_fire_i && (cfg_index_i == REG_FRAME_W || cfg_index_i == REG_FRAME_H)) begin
      x_d = '0;
      y_d = '0;
    end else if (div_done && cmd_i.job == JOB_SEEDX) begin
      cx_d = seed_cnt;
      ox_d = rem[COORD_W-1:0];
    end else if (div_done && cmd_i.job == JOB_SEEDY) begin
      cy_d = seed_cnt;
      oy_d = rem[COORD_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q  <= '0;
      y_q  <= '0;
      cx_q <= '0;
      cy_q <= '0;
      ox_q <= '0;
      oy_q <= '0;
    end else begin
      x_q  <= x_d;
      y_q  <= y_d;
      cx_q <= cx_d;
      cy_q <= cy_d;
      ox_q <= ox_d;
      oy_q <= oy_d;
    end
  end

  // Stage 1 (store read) and stage 2 (output register)
  logic               s1_v_q, out_v_q, s1_move;
  logic [COORD_W-1:0] s1_x_q, s1_y_q;
  logic               s1_in_q, s1_last_q, s1_two_q;
  logic [VAL_W-1:0]   pix_q;
  logic [COORD_W-1:0] px_q, py_q;
  logic               pin_q, pend_q;

  assign s1_move = s1_v_q && (!out_v_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (in_fire_i && is_tick) s1_v_q <= 1'b1;
      else if (s1_move)         s1_v_q <= 1'b0;
      if (s1_move)          out_v_q <= 1'b1;
      else if (out_ready_i) out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire_i && is_tick) begin
      s1_x_q    <= x_q;
      s1_y_q    <= y_q;
      s1_in_q   <= in_area;
      s1_last_q <= end_x && end_y;
      s1_two_q  <= two_byte_q;
    end
    if (s1_move) begin
      if (!s1_in_q)      pix_q <= '0;
      else if (s1_two_q) pix_q <= rd_q;
      else               pix_q <= {{BYTE_W{1'b0}}, rd_q[BYTE_W-1:0]};
      px_q   <= s1_x_q;
      py_q   <= s1_y_q;
      pin_q  <= s1_in_q;
      pend_q <= s1_last_q;
    end
  end

  assign stat_o.div_done = div_done;
  assign stat_o.can_take = !s1_v_q || s1_move;

  assign out_valid_o   = out_v_q;
  assign pixel_value_o = pix_q;
  assign pixel_x_o     = px_q;
  assign pixel_y_o     = py_q;
  assign inside_bins_o = pin_q;
  assign frame_end_o   = pend_q;

endmodule

// ----- hw/rtl/bbu_ctrl.sv -----
// Controller: store clearing sweep, geometry recompute sequence and run state.
module bbu_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_fire_i,
  input  bbu_pkg::bbu_stat_t  stat_i,
  output bbu_pkg::bbu_cmd_t   cmd_o
);
  import bbu_pkg::*;

  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_START  = 3'd1;
  localparam logic [2:0] ST_WAIT   = 3'd2;
  localparam logic [2:0] ST_MARGIN = 3'd3;
  localparam logic [2:0] ST_RUN    = 3'd4;

  logic [2:0]          state_q, state_d;
  logic [1:0]          job_q, job_d;
  logic [STORE_AW-1:0] clr_cnt_q, clr_cnt_d;

  // Next state
  always_comb begin
    state_d   = state_q;
    job_d     = job_q;
    clr_cnt_d = clr_cnt_q;
    case (state_q)
      ST_CLEAR: begin
        clr_cnt_d = clr_cnt_q + STORE_AW'(1);
        if (clr_cnt_q == '1) begin
          state_d = ST_START;
          job_d   = JOB_COLS;
        end
      end
      ST_START: state_d = ST_WAIT;
      ST_WAIT: begin
        if (stat_i.div_done) begin
          case (job_q)
            JOB_COLS: begin
              job_d   = JOB_ROWS;
              state_d = ST_START;
            end
            JOB_ROWS:  state_d = ST_MARGIN;
            JOB_SEEDX: begin
              job_d   = JOB_SEEDY;
              state_d = ST_START;
            end
            default:   state_d = ST_RUN;
          endcase
        end
      end
      ST_MARGIN: begin
        job_d   = JOB_SEEDX;
        state_d = ST_START;
      end
      ST_RUN: begin
        if (cfg_fire_i) begin
          job_d   = JOB_COLS;
          state_d = ST_START;
        end
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      job_q     <= JOB_COLS;
      clr_cnt_q <= '0;
    end else begin
      state_q   <= state_d;
      job_q     <= job_d;
      clr_cnt_q <= clr_cnt_d;
    end
  end

  // Commands
  assign cmd_o.clr_we    = state_q == ST_CLEAR;
  assign cmd_o.clr_addr  = clr_cnt_q;
  assign cmd_o.div_start = state_q == ST_START;
  assign cmd_o.job       = job_q;
  assign cmd_o.margin_ld = state_q == ST_MARGIN;
  assign cmd_o.run       = state_q == ST_RUN;
  assign cmd_o.cfg_open  = (state_q == ST_RUN) || (state_q == ST_CLEAR);

endmodule

// ----- hw/rtl/bin_block_upscaler_core.sv -----
// Bin block upscaler: expands a centered grid of stored bins into raster pixels.
// Throughput: one request per cycle (store writes and pixel ticks alike) while
// in_ready_o is high: in the run state, with no output back-pressure and no
// config write offered. Pixel tick results pass the store read register, then
// the output register. Reset: a pass zeroes all 4096 store entries, then the
// 13-step divider rebuilds the geometry; each config write repeats the rebuild.
module bin_block_upscaler_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // request channel
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [1:0]                     kind_i,
  input  logic [5:0]                     bin_column_i,
  input  logic [5:0]                     bin_row_i,
  input  logic [bbu_pkg::STORE_AW-1:0]   bin_index_i,
  input  logic [bbu_pkg::VAL_W-1:0]      bin_value_i,
  // result channel
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [bbu_pkg::VAL_W-1:0]      pixel_value_o,
  output logic [bbu_pkg::COORD_W-1:0]    pixel_x_o,
  output logic [bbu_pkg::COORD_W-1:0]    pixel_y_o,
  output logic                           inside_bins_o,
  output logic                           frame_end_o,
  // configuration channel
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [bbu_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [bbu_pkg::DIM_W-1:0]      cfg_data_i
);
  import bbu_pkg::*;

  bbu_cmd_t  cmd;
  bbu_stat_t stat;
  logic      cfg_fire, in_fire;

  // Requests wait while a config write is offered
  assign cfg_ready_o = cmd.cfg_open;
  assign cfg_fire    = cfg_valid_i && cfg_ready_o;
  assign in_ready_o  = cmd.run && stat.can_take && !cfg_valid_i;
  assign in_fire     = in_valid_i && in_ready_o;

  bbu_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_fire_i (cfg_fire),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  bbu_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .cfg_fire_i    (cfg_fire),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_fire_i     (in_fire),
    .kind_i        (kind_i),
    .bin_column_i  (bin_column_i),
    .bin_row_i     (bin_row_i),
    .bin_index_i   (bin_index_i),
    .bin_value_i   (bin_value_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .pixel_value_o (pixel_value_o),
    .pixel_x_o     (pixel_x_o),
    .pixel_y_o     (pixel_y_o),
    .inside_bins_o (inside_bins_o),
    .frame_end_o   (frame_end_o)
  );

endmodule
